FILE: src/windowed_move_dispatch_queue_macros.svh
`ifndef WINDOWED_MOVE_DISPATCH_QUEUE_MACROS_SVH
`define WINDOWED_MOVE_DISPATCH_QUEUE_MACROS_SVH

// Clocked assertion on clk_i, switched off while rst_ni is low.
`define WMDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define WMDQ_NEVER(lbl, cond, msg) \
  `WMDQ_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/wmdq_pkg.sv
package wmdq_pkg;

  localparam int ID_W     = 32;
  localparam int KIND_W   = 3;
  localparam int COORD_W  = 16;
  localparam int WINDOW_W = 5;

  localparam int PEND_DEPTH = 32;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);
  localparam int PEND_CW    = $clog2(PEND_DEPTH + 1);

  localparam int SENT_DEPTH = 16;
  localparam int SENT_AW    = $clog2(SENT_DEPTH);
  localparam int SENT_CW    = $clog2(SENT_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } move_t;

  typedef struct packed {
    logic push;
    logic pop;
  } pend_ctrl_t;

endpackage

FILE: src/wmdq_pend_fifo.sv
`include "windowed_move_dispatch_queue_macros.svh"

module wmdq_pend_fifo (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  wmdq_pkg::pend_ctrl_t                    ctrl_i,
  input  wmdq_pkg::move_t                         push_entry_i,
  output wmdq_pkg::move_t                         head_o,
  output logic [wmdq_pkg::PEND_CW-1:0]            cnt_o,
  output logic [wmdq_pkg::PEND_CW-1:0]            cnt_next_o
);
  import wmdq_pkg::*;

  move_t               mem_q [PEND_DEPTH];
  logic [PEND_AW-1:0]  head_q, head_d;
  logic [PEND_AW-1:0]  tail_q, tail_d;
  logic [PEND_CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == PEND_AW'(PEND_DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == PEND_AW'(PEND_DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_entry_i;
    end
  end

  assign head_o     = mem_q[head_q];
  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;

  `WMDQ_NEVER(a_pop_empty, ctrl_i.pop && (cnt_q == '0), "pop from empty pending queue")
  `WMDQ_NEVER(a_push_full, ctrl_i.push && (cnt_q == PEND_CW'(PEND_DEPTH)), "push to full pending queue")
  `WMDQ_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (head_q == tail_q), "empty queue with unequal pointers")

endmodule

FILE: src/wmdq_sent_list.sv
module wmdq_sent_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [wmdq_pkg::ID_W-1:0]   push_id_i,
  input  logic [wmdq_pkg::ID_W-1:0]   arm_index_i
);
  import wmdq_pkg::*;

  logic [ID_W-1:0]     ids_q [SENT_DEPTH];
  logic [SENT_AW-1:0]  head_q, head_d, head_mid;
  logic [SENT_AW-1:0]  tail_q, tail_d;
  logic [SENT_CW-1:0]  cnt_q, cnt_d, cnt_mid;
  logic                full;
  logic [ID_W-1:0]     oldest_id;

  function automatic logic [SENT_AW-1:0] ptr_inc(input logic [SENT_AW-1:0] p);
    return (p == SENT_AW'(SENT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (cnt_q == SENT_CW'(SENT_DEPTH));

  // A full list drops its oldest entry to make room; the oldest surviving entry
  // is then retired once the arm has moved past it. When the list was empty the
  // oldest entry is the one being written now.
  always_comb begin
    head_mid  = full ? ptr_inc(head_q) : head_q;
    cnt_mid   = full ? cnt_q : cnt_q + 1'b1;
    oldest_id = (head_mid == tail_q) ? push_id_i : ids_q[head_mid];
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    if (push_i) begin
      tail_d = ptr_inc(tail_q);
      head_d = head_mid;
      cnt_d  = cnt_mid;
      if (arm_index_i > oldest_id) begin
        head_d = ptr_inc(head_mid);
        cnt_d  = cnt_mid - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ids_q[tail_q] <= push_id_i;
    end
  end

endmodule

FILE: src/windowed_move_dispatch_queue.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o    | action, move_kind, target_x/y/z, in_limits,
//          |                            | arm_index
// result   | out_valid_o / out_stall_i  | status, dispatched, sent_id, sent_kind,
//          |                            | sent_x/y/z, covering_view, pending_count
// config   | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One transaction is taken per cycle unless a stalled result blocks the input.
// All per-transaction work (pending queue head read, 32-bit ID compares) sits between
// the input register and the result register.
// Reset is asynchronous: IDs restart at next 1, actual 0, escape 0, queues empty.
// A stalled result holds; a full input register then holds and in_stall_o rises.
`include "windowed_move_dispatch_queue_macros.svh"

module windowed_move_dispatch_queue (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [2:0]                                cfg_idx_i,
  input  logic [wmdq_pkg::COORD_W-1:0]              cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [2:0]                                action_i,
  input  logic [wmdq_pkg::KIND_W-1:0]               move_kind_i,
  input  logic signed [wmdq_pkg::COORD_W-1:0]       target_x_i,
  input  logic signed [wmdq_pkg::COORD_W-1:0]       target_y_i,
  input  logic signed [wmdq_pkg::COORD_W-1:0]       target_z_i,
  input  logic                                      in_limits_i,
  input  logic [wmdq_pkg::ID_W-1:0]                 arm_index_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [2:0]                                status_o,
  output logic                                      dispatched_o,
  output logic [wmdq_pkg::ID_W-1:0]                 sent_id_o,
  output logic [wmdq_pkg::KIND_W-1:0]               sent_kind_o,
  output logic signed [wmdq_pkg::COORD_W-1:0]       sent_x_o,
  output logic signed [wmdq_pkg::COORD_W-1:0]       sent_y_o,
  output logic signed [wmdq_pkg::COORD_W-1:0]       sent_z_o,
  output logic                                      covering_view_o,
  output logic [wmdq_pkg::PEND_CW-1:0]              pending_count_o
);
  import wmdq_pkg::*;

  localparam logic [2:0] ACT_ENQUEUE = 3'd0;
  localparam logic [2:0] ACT_POLL    = 3'd1;
  localparam logic [2:0] ACT_SYNC    = 3'd2;
  localparam logic [2:0] ACT_ESCAPE  = 3'd3;
  localparam logic [2:0] ACT_ARM     = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LIMITS  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOTHING = 3'd3;
  localparam logic [2:0] ST_ORDER   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_POINT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;

  localparam logic [2:0] CFG_WINDOW  = 3'd0;
  localparam logic [2:0] CFG_LEFT_X  = 3'd1;
  localparam logic [2:0] CFG_LEFT_Y  = 3'd2;
  localparam logic [2:0] CFG_LEFT_Z  = 3'd3;
  localparam logic [2:0] CFG_RIGHT_X = 3'd4;
  localparam logic [2:0] CFG_RIGHT_Y = 3'd5;
  localparam logic [2:0] CFG_RIGHT_Z = 3'd6;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd15;

  // Configuration registers.
  logic [WINDOW_W-1:0]       window_q;
  logic signed [COORD_W-1:0] left_x_q, left_y_q, left_z_q;
  logic signed [COORD_W-1:0] right_x_q, right_y_q, right_z_q;

  // Input register.
  logic                      s1_valid_q;
  logic [2:0]                s1_action_q;
  logic [KIND_W-1:0]         s1_kind_q;
  logic signed [COORD_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                      s1_lim_q;
  logic [ID_W-1:0]           s1_idx_q;
  logic                      s1_fire;
  logic                      in_accept;

  // Sequence state.
  logic [ID_W-1:0] next_id_q, next_id_d;
  logic [ID_W-1:0] actual_id_q, actual_id_d;
  logic [ID_W-1:0] escape_id_q, escape_id_d;
  logic            armed_q, armed_d;
  logic [ID_W-1:0] next_inc;

  // Pending queue interface.
  pend_ctrl_t          pend_ctrl;
  move_t               push_entry, head;
  logic [PEND_CW-1:0]  pend_cnt, pend_cnt_next;
  logic                pend_full;

  // Escape point selection.
  logic signed [COORD_W:0] dy_l, dy_r;
  logic [COORD_W:0]        ady_l, ady_r;
  logic                    pick_right;

  logic                    lim_ok;
  logic [ID_W-1:0]         head_ahead;
  logic [2:0]              status;
  logic                    disp;
  logic                    covering;

  // Result register.
  logic                      out_valid_q;
  logic [2:0]                out_status_q;
  logic                      out_disp_q;
  move_t                     out_move_q;
  logic                      out_cover_q;
  logic [PEND_CW-1:0]        out_cnt_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RESET;
      left_x_q  <= '0;
      left_y_q  <= '0;
      left_z_q  <= '0;
      right_x_q <= '0;
      right_y_q <= '0;
      right_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW:  window_q  <= cfg_wdata_i[WINDOW_W-1:0];
        CFG_LEFT_X:  left_x_q  <= cfg_wdata_i;
        CFG_LEFT_Y:  left_y_q  <= cfg_wdata_i;
        CFG_LEFT_Z:  left_z_q  <= cfg_wdata_i;
        CFG_RIGHT_X: right_x_q <= cfg_wdata_i;
        CFG_RIGHT_Y: right_y_q <= cfg_wdata_i;
        CFG_RIGHT_Z: right_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_kind_q   <= move_kind_i;
      s1_x_q      <= target_x_i;
      s1_y_q      <= target_y_i;
      s1_z_q      <= target_z_i;
      s1_lim_q    <= in_limits_i;
      s1_idx_q    <= arm_index_i;
    end
  end

  // The right retreat point wins only when strictly nearer in y.
  always_comb begin
    dy_l       = {s1_y_q[COORD_W-1], s1_y_q} - {left_y_q[COORD_W-1], left_y_q};
    dy_r       = {s1_y_q[COORD_W-1], s1_y_q} - {right_y_q[COORD_W-1], right_y_q};
    ady_l      = dy_l[COORD_W] ? $unsigned(-dy_l) : $unsigned(dy_l);
    ady_r      = dy_r[COORD_W] ? $unsigned(-dy_r) : $unsigned(dy_r);
    pick_right = ady_l > ady_r;
  end

  assign next_inc  = (next_id_q == '1) ? next_id_q : next_id_q + 1'b1;
  assign pend_full = (pend_cnt == PEND_CW'(PEND_DEPTH));
  assign head_ahead = head.id - s1_idx_q;

  always_comb begin
    next_id_d   = next_id_q;
    actual_id_d = actual_id_q;
    escape_id_d = escape_id_q;
    armed_d     = armed_q;
    status      = ST_OK;
    disp        = 1'b0;
    pend_ctrl   = '0;
    lim_ok      = 1'b0;
    push_entry  = '{id: next_inc, kind: s1_kind_q, x: s1_x_q, y: s1_y_q, z: s1_z_q};
    unique case (s1_action_q) inside
      ACT_ENQUEUE, ACT_ESCAPE: begin
        if (s1_action_q == ACT_ESCAPE) begin
          push_entry.kind = KIND_POINT;
          push_entry.x    = pick_right ? right_x_q : left_x_q;
          push_entry.y    = pick_right ? right_y_q : left_y_q;
          push_entry.z    = pick_right ? right_z_q : left_z_q;
        end
        lim_ok = (push_entry.kind == KIND_OPEN) || (push_entry.kind == KIND_CLOSE) ||
                 s1_lim_q;
        if (!lim_ok) begin
          status = ST_LIMITS;
        end else if (pend_full) begin
          status = ST_FULL;
        end else begin
          pend_ctrl.push = s1_fire;
          next_id_d      = next_inc;
        end
        if (s1_action_q == ACT_ESCAPE) begin
          escape_id_d = next_id_d;
          armed_d     = 1'b0;
        end
      end
      ACT_POLL: begin
        actual_id_d = s1_idx_q;
        if (pend_cnt == '0) begin
          status = ST_NOTHING;
        end else if (head.id < s1_idx_q) begin
          status = ST_ORDER;
        end else if (head_ahead < {{(ID_W-WINDOW_W){1'b0}}, window_q}) begin
          disp          = 1'b1;
          pend_ctrl.pop = s1_fire;
        end else begin
          status = ST_NOTHING;
        end
      end
      ACT_SYNC: begin
        actual_id_d = s1_idx_q;
        next_id_d   = s1_idx_q;
        escape_id_d = s1_idx_q;
      end
      ACT_ARM: begin
        armed_d = 1'b1;
      end
      default: ;
    endcase
    covering = armed_d && (actual_id_d > escape_id_d) && (actual_id_d >= next_id_d) &&
               (pend_cnt_next == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= ID_W'(1);
      actual_id_q <= '0;
      escape_id_q <= '0;
      armed_q     <= 1'b0;
    end else if (s1_fire) begin
      next_id_q   <= next_id_d;
      actual_id_q <= actual_id_d;
      escape_id_q <= escape_id_d;
      armed_q     <= armed_d;
    end
  end

  wmdq_pend_fifo u_pend_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (pend_ctrl),
    .push_entry_i (push_entry),
    .head_o       (head),
    .cnt_o        (pend_cnt),
    .cnt_next_o   (pend_cnt_next)
  );

  wmdq_sent_list u_sent_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pend_ctrl.pop),
    .push_id_i   (head.id),
    .arm_index_i (s1_idx_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_status_q <= status;
      out_disp_q   <= disp;
      out_move_q   <= disp ? head : '0;
      out_cover_q  <= covering;
      out_cnt_q    <= pend_cnt_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign dispatched_o    = out_disp_q;
  assign sent_id_o       = out_move_q.id;
  assign sent_kind_o     = out_move_q.kind;
  assign sent_x_o        = out_move_q.x;
  assign sent_y_o        = out_move_q.y;
  assign sent_z_o        = out_move_q.z;
  assign covering_view_o = out_cover_q;
  assign pending_count_o = out_cnt_q;

  `WMDQ_ASSERT(a_disp_ok, (out_valid_q && out_disp_q) |-> (out_status_q == ST_OK), "dispatch with error status")
  `WMDQ_NEVER(a_stall_empty, in_stall_o && !s1_valid_q, "input stalled with empty input register")
  `WMDQ_ASSERT(a_id_rises, (s1_fire && (s1_action_q != ACT_SYNC)) |=> (next_id_q >= $past(next_id_q)), "sequence ID went backwards")

endmodule
